// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sdm_pkg.sv =====
// Shared types, widths and constants of the surround downmix block.
// No dependencies; imported by every module and interface of the block.
package sdm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_LIMIT     = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;

  localparam int SAMPLE_W   = 32;
  localparam int CH_W       = 3;
  localparam int COUNT_W    = 4;
  localparam int ROLE_W     = 4;
  localparam int ROLES_W    = 32;
  localparam int ACC_W      = 40;
  localparam int WGT_W      = 17;
  localparam int PROD_W     = 50;
  localparam int ADD_W      = 33;
  localparam int WSUM_W     = 20;
  localparam int NUM_W      = 48;
  localparam int QUO_W      = 16;
  localparam int STEP_W     = 4;
  localparam int BIG_W      = 24;
  localparam int PCM_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Q1.16 weights
  localparam logic [WGT_W-1:0] W_ONE        = 17'd65536;
  localparam logic [WGT_W-1:0] W_HALF_POWER = 17'd46341;
  localparam logic [WGT_W-1:0] W_HALF       = 17'd32768;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef enum logic [ROLE_W-1:0] {
    ROLE_NONE    = 4'd0,
    ROLE_LEFT    = 4'd1,
    ROLE_RIGHT   = 4'd2,
    ROLE_CENTER  = 4'd3,
    ROLE_SURR_L  = 4'd4,
    ROLE_SURR_R  = 4'd5,
    ROLE_BACK_C  = 4'd6,
    ROLE_UNNAMED = 4'd7
  } role_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOWNMIX_EN    = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_CHANNEL_ROLES = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACC,
    ST_SUM,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic               downmix;
    logic [COUNT_W-1:0] count;
    logic [ROLES_W-1:0] roles;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic acc_clear;
    logic sum_clear;
    logic sum_step;
    logic div_load;
    logic div_step;
    logic load_pass;
    logic load_div;
    logic side;
  } dp_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic is_last;
    logic downmix;
    logic out_free;
    logic sum_done;
    logic div_done;
  } dp_status_t;

endpackage

// ===== rtl/core/sdm_if.sv =====
// Handshake interfaces of the block: sample input, PCM output, config write.
// Depends on sdm_pkg for field widths.
interface sdm_in_if import sdm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic        [CH_W-1:0]     channel_index;

  modport source (output valid, output sample_value, output channel_index, input ready);
  modport sink   (input valid, input sample_value, input channel_index, output ready);
endinterface

interface sdm_out_if import sdm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PCM_W-1:0] pcm_value;
  logic        [CH_W-1:0]  out_channel;
  logic                    frame_last;

  modport source (output valid, output pcm_value, output out_channel, output frame_last,
                  input ready);
  modport sink   (input valid, input pcm_value, input out_channel, input frame_last,
                  output ready);
endinterface

interface sdm_cfg_if import sdm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/surround_downmix_to_pcm16.sv =====
// Top level of the surround downmix to 16-bit PCM block.
// Depends on sdm_pkg, sdm_if, sdm_cfg_regs, sdm_ctrl and sdm_datapath.
//
//   port    dir   word                                        handshake
//   cfg_i   in    index, data                                 valid/ready, ready always high
//   in_i    in    sample_value (Q8.24), channel_index         valid/ready
//   out_o   out   pcm_value, out_channel, frame_last          valid/ready
//
// Pass-through: each word is accepted, then converted into the output register.
// Downmix, inner channel: accept, multiply, accumulate.
// Downmix, last channel: accept, multiply, accumulate, weight sum (one channel a cycle),
// then the 16-step restoring divider run once per side; two words result.
// Reset clears the accumulators and empties the output register; registers go to 0, 2, 0.
// A word waiting in the output register does not block input; a conversion holds
// until the register is free.
module surround_downmix_to_pcm16 import sdm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdm_cfg_if.sink   cfg_i,
  sdm_in_if.sink    in_i,
  sdm_out_if.source out_o
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  sdm_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  sdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sdm_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .sample_value_i  (in_i.sample_value),
    .channel_index_i (in_i.channel_index),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .pcm_value_o     (out_o.pcm_value),
    .out_channel_o   (out_o.out_channel),
    .frame_last_o    (out_o.frame_last)
  );

endmodule

// ===== rtl/core/sdm_cfg_regs.sv =====
// Configuration registers and derived frame settings.
// Depends on sdm_pkg and sdm_cfg_if.
module sdm_cfg_regs import sdm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  sdm_cfg_if.sink cfg_i,
  output cfg_t    cfg_o
);

  logic               downmix_en_q, downmix_en_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [ROLES_W-1:0] roles_q, roles_d;
  logic [COUNT_W-1:0] count_eff;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    downmix_en_d = downmix_en_q;
    count_d      = count_q;
    roles_d      = roles_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_DOWNMIX_EN:    downmix_en_d = cfg_i.data[0];
        CFG_CHANNEL_COUNT: count_d      = cfg_i.data[COUNT_W-1:0];
        CFG_CHANNEL_ROLES: roles_d      = cfg_i.data[ROLES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      downmix_en_q <= 1'b0;
      count_q      <= COUNT_W'(2);
      roles_q      <= '0;
    end else begin
      downmix_en_q <= downmix_en_d;
      count_q      <= count_d;
      roles_q      <= roles_d;
    end
  end

  // zero counts as one channel, large counts clamp to the channel limit
  always_comb begin
    if (count_q == '0) begin
      count_eff = COUNT_W'(1);
    end else if (count_q > COUNT_W'(CH_LIMIT)) begin
      count_eff = COUNT_W'(CH_LIMIT);
    end else begin
      count_eff = count_q;
    end
  end

  assign cfg_o.downmix = downmix_en_q && (count_eff > COUNT_W'(2));
  assign cfg_o.count   = count_eff;
  assign cfg_o.roles   = roles_q;

endmodule

// ===== rtl/core/sdm_ctrl.sv =====
// Sequencer: accepts a word and has the datapath convert it, or
// multiply, accumulate, weight-sum, divide twice. Depends on sdm_pkg.
module sdm_ctrl import sdm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        side_q, side_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      side_q  <= SIDE_LEFT;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    side_d     = side_q;
    cmd_o      = '0;
    cmd_o.side = side_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status_i.ch_ok) begin
          // drop a channel beyond the frame
          state_d = ST_IDLE;
        end else if (!status_i.downmix) begin
          if (status_i.out_free) begin
            cmd_o.load_pass = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (status_i.is_last) begin
          cmd_o.sum_clear = 1'b1;
          state_d         = ST_SUM;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (status_i.sum_done) begin
          side_d  = SIDE_LEFT;
          state_d = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_div = 1'b1;
          if (side_q == SIDE_RIGHT) begin
            cmd_o.acc_clear = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            side_d  = SIDE_RIGHT;
            state_d = ST_DIV_LOAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/sdm_datapath.sv =====
// Datapath: weight multiply, saturating accumulators, weight sums,
// restoring divider, PCM rounding and clipping, output register. Depends on sdm_pkg.
module sdm_datapath import sdm_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  dp_cmd_t                    cmd_i,
  output dp_status_t                 status_o,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  input  logic        [CH_W-1:0]     channel_index_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [PCM_W-1:0]    pcm_value_o,
  output logic        [CH_W-1:0]     out_channel_o,
  output logic                       frame_last_o
);

  function automatic logic [WGT_W-1:0] weight_left(logic [ROLE_W-1:0] r);
    logic [WGT_W-1:0] w;
    case (role_e'(r))
      ROLE_LEFT:               w = W_ONE;
      ROLE_CENTER, ROLE_SURR_L: w = W_HALF_POWER;
      ROLE_BACK_C:             w = W_HALF;
      ROLE_NONE, ROLE_UNNAMED: w = '0;
      default:                 w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [WGT_W-1:0] weight_right(logic [ROLE_W-1:0] r);
    logic [WGT_W-1:0] w;
    case (role_e'(r))
      ROLE_RIGHT:               w = W_ONE;
      ROLE_CENTER, ROLE_SURR_R: w = W_HALF_POWER;
      ROLE_BACK_C:              w = W_HALF;
      default:                  w = '0;
    endcase
    return w;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                      logic signed [ADD_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {{(ACC_W + 1 - ADD_W){b[ADD_W-1]}}, b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  // big is the rounded magnitude; clip to the 16-bit range on its side
  function automatic logic [PCM_W-1:0] pcm_clip(logic neg, logic [BIG_W-1:0] big);
    logic [BIG_W-1:0] t;
    t = ~big + BIG_W'(1);
    if (neg) begin
      return (big > BIG_W'(32768)) ? 16'h8000 : t[PCM_W-1:0];
    end
    return (big > BIG_W'(32767)) ? 16'h7fff : big[PCM_W-1:0];
  endfunction

  logic signed [SAMPLE_W-1:0] x_q;
  logic        [CH_W-1:0]     ch_q;
  logic signed [PROD_W-1:0]   prod_l_q, prod_r_q;
  logic signed [ACC_W-1:0]    acc_l_q, acc_r_q;
  logic        [WSUM_W-1:0]   sum_l_q, sum_r_q;
  logic        [CH_W-1:0]     cnt_q;
  logic        [NUM_W-1:0]    rem_q, dsh_q;
  logic        [QUO_W-1:0]    quo_q;
  logic        [STEP_W-1:0]   step_q;
  logic                       ovf_q, neg_q;
  logic                       out_valid_q;
  logic        [PCM_W-1:0]    pcm_q;
  logic        [CH_W-1:0]     och_q;
  logic                       last_q;

  logic [COUNT_W-1:0]       n_m1;
  logic [ROLE_W-1:0]        role_x, role_c;
  logic signed [WGT_W:0]    wl_s, wr_s;
  logic signed [ACC_W-1:0]  acc_sel;
  logic [ACC_W-1:0]         mag;
  logic [WSUM_W-1:0]        d_max;
  logic [WSUM_W:0]          dv;
  logic [NUM_W-1:0]         num, lim, dsh_init;
  logic                     rem_ge;
  logic [SAMPLE_W-1:0]      mag_x;
  logic [SAMPLE_W:0]        pass_sum;
  logic                     out_free;

  assign n_m1   = cfg_i.count - COUNT_W'(1);
  assign role_x = cfg_i.roles[{ch_q, 2'b00} +: ROLE_W];
  assign role_c = cfg_i.roles[{cnt_q, 2'b00} +: ROLE_W];
  assign wl_s   = {1'b0, weight_left(role_x)};
  assign wr_s   = {1'b0, weight_right(role_x)};

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.ch_ok    = {1'b0, ch_q} < cfg_i.count;
  assign status_o.is_last  = {1'b0, ch_q} == n_m1;
  assign status_o.downmix  = cfg_i.downmix;
  assign status_o.out_free = out_free;
  assign status_o.sum_done = cnt_q == n_m1[CH_W-1:0];
  assign status_o.div_done = step_q == '0;

  // numerator |acc|*256 + D over divisor 2D gives the half-away rounding
  always_comb begin
    acc_sel  = (cmd_i.side == SIDE_RIGHT) ? acc_r_q : acc_l_q;
    mag      = acc_sel[ACC_W-1] ? (~acc_sel + ACC_W'(1)) : acc_sel;
    d_max    = WSUM_W'(W_ONE);
    if (sum_l_q > d_max) begin
      d_max = sum_l_q;
    end
    if (sum_r_q > d_max) begin
      d_max = sum_r_q;
    end
    dv       = {d_max, 1'b0};
    num      = {mag, 8'b0} + NUM_W'(d_max);
    lim      = {{(NUM_W - WSUM_W - 1 - QUO_W){1'b0}}, dv, {QUO_W{1'b0}}};
    dsh_init = {{(NUM_W - WSUM_W - QUO_W){1'b0}}, dv, {(QUO_W-1){1'b0}}};
  end

  assign rem_ge   = rem_q >= dsh_q;
  assign mag_x    = x_q[SAMPLE_W-1] ? (~x_q + SAMPLE_W'(1)) : x_q;
  assign pass_sum = {1'b0, mag_x} + (SAMPLE_W + 1)'(256);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_l_q     <= '0;
      acc_r_q     <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.acc_clear) begin
        acc_l_q <= '0;
        acc_r_q <= '0;
      end else if (cmd_i.acc) begin
        acc_l_q <= sat_add(acc_l_q, prod_l_q[QUO_W +: ADD_W]);
        acc_r_q <= sat_add(acc_r_q, prod_r_q[QUO_W +: ADD_W]);
      end
      if (cmd_i.load_pass || cmd_i.load_div) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.div_load) begin
        step_q <= STEP_W'(QUO_W - 1);
      end else if (cmd_i.div_step) begin
        step_q <= step_q - STEP_W'(1);
      end
      if (cmd_i.sum_clear) begin
        cnt_q <= '0;
      end else if (cmd_i.sum_step) begin
        cnt_q <= cnt_q + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q  <= sample_value_i;
      ch_q <= channel_index_i;
    end
    if (cmd_i.mul) begin
      prod_l_q <= x_q * wl_s;
      prod_r_q <= x_q * wr_s;
    end
    if (cmd_i.sum_clear) begin
      sum_l_q <= '0;
      sum_r_q <= '0;
    end else if (cmd_i.sum_step) begin
      sum_l_q <= sum_l_q + WSUM_W'(weight_left(role_c));
      sum_r_q <= sum_r_q + WSUM_W'(weight_right(role_c));
    end
    if (cmd_i.div_load) begin
      rem_q <= num;
      dsh_q <= dsh_init;
      ovf_q <= num >= lim;
      neg_q <= acc_sel[ACC_W-1];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], rem_ge};
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.load_pass) begin
      pcm_q  <= pcm_clip(x_q[SAMPLE_W-1], pass_sum[SAMPLE_W:9]);
      och_q  <= ch_q;
      last_q <= status_o.is_last;
    end else if (cmd_i.load_div) begin
      pcm_q  <= pcm_clip(neg_q, ovf_q ? {BIG_W{1'b1}} : BIG_W'(quo_q));
      och_q  <= {{(CH_W-1){1'b0}}, cmd_i.side};
      last_q <= cmd_i.side;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pcm_value_o   = pcm_q;
  assign out_channel_o = och_q;
  assign frame_last_o  = last_q;

endmodule

// ===== rtl/core/sdm_checker.sv =====
// Port-level checks of the surround downmix block, bound to the top level.
// Depends on assert_macros.svh and sdm_pkg.
`include "assert_macros.svh"

module sdm_checker import sdm_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [PCM_W-1:0] pcm_value_i,
  input logic        [CH_W-1:0]  out_channel_i,
  input logic                    frame_last_i
);

  // hold a stalled word
  `ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output word dropped while stalled")
  `ASSERT_NEXT(a_out_word_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(pcm_value_i) && $stable(out_channel_i) && $stable(frame_last_i), "output word changed while stalled")

  // one word at a time: the cycle after an accept never takes another
  `ASSERT_NEXT(a_in_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input accepted on back-to-back cycles")

  // a fresh output word is only loaded while input is closed
  `ASSERT_IMPLY(a_load_while_busy, clk_i, rst_ni, out_valid_i && !$past(out_valid_i && !out_ready_i), !$past(in_ready_i), "output loaded while input was open")

endmodule

bind surround_downmix_to_pcm16 sdm_checker u_sdm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .pcm_value_i   (out_o.pcm_value),
  .out_channel_i (out_o.out_channel),
  .frame_last_i  (out_o.frame_last)
);

// ===== tb/surround_downmix_to_pcm16_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for surround_downmix_to_pcm16: drives sample words and config
// writes, predicts every PCM word in-line and compares it with the block's output.
// Depends on sdm_pkg, the sdm_if interfaces and the RTL of the block.
module surround_downmix_to_pcm16_test;
  import sdm_pkg::*;

  localparam int     ITEM_TARGET   = 1950;
  localparam int     SETTLE_CYCLES = 64;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     MAX_REPORTS   = 10;
  localparam int     CYCLE_LIMIT   = 1000000;
  localparam longint ACC_TOP       = 64'sd549755813887;
  localparam longint ACC_BOTTOM    = -ACC_TOP - 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic        [CH_W-1:0]     chan;
  } sample_word_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm;
    logic        [CH_W-1:0]  chan;
    logic                    last;
  } pcm_word_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_EVERY4, SINK_SPARSE} sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  sdm_cfg_if cfg_if ();
  sdm_in_if  in_if ();
  sdm_out_if out_if ();

  surround_downmix_to_pcm16 uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the block's registers and accumulators
  logic               model_downmix;
  logic [COUNT_W-1:0] model_count;
  logic [ROLES_W-1:0] model_roles;
  longint             acc_left;
  longint             acc_right;

  sample_word_t pending_samples[$];
  pcm_word_t    pcm_expected[$];
  int           issued;
  int           mismatch_count;
  int           cycle_count;

  int         gap_left;
  int         burst_left;
  sink_mode_e sink_mode;
  int         mode_left;
  logic [1:0] sink_tick;
  int         hold_left;
  logic       hold_request;
  logic       hold_used;

  function automatic int eff_channels();
    int n;
    n = int'(model_count);
    if (n == 0) n = 1;
    if (n > CH_LIMIT) n = CH_LIMIT;
    return n;
  endfunction

  function automatic void role_gain(input logic [ROLE_W-1:0] role, output longint gl,
                                    output longint gr);
    gl = 0;
    gr = 0;
    case (role)
      ROLE_LEFT: gl = W_ONE;
      ROLE_RIGHT: gr = W_ONE;
      ROLE_CENTER: begin
        gl = W_HALF_POWER;
        gr = W_HALF_POWER;
      end
      ROLE_SURR_L: gl = W_HALF_POWER;
      ROLE_SURR_R: gr = W_HALF_POWER;
      ROLE_BACK_C: begin
        gl = W_HALF;
        gr = W_HALF;
      end
      default: ;
    endcase
  endfunction

  function automatic longint clamp_acc(longint s);
    if (s > ACC_TOP) return ACC_TOP;
    if (s < ACC_BOTTOM) return ACC_BOTTOM;
    return s;
  endfunction

  // round(acc * 128 / dn) half away from zero, then clip to 16 bits
  function automatic logic signed [PCM_W-1:0] scale_to_pcm(longint acc, longint unsigned dn);
    longint unsigned mag;
    longint unsigned q;
    mag = (acc < 0) ? -acc : acc;
    q = (mag * 256 + dn) / (2 * dn);
    if (acc < 0) begin
      if (q > 64'd32768) return 16'sh8000;
      return 16'(-longint'(q));
    end
    if (q > 64'd32767) return 16'sh7FFF;
    return 16'(q);
  endfunction

  task automatic fold_sample(input logic signed [SAMPLE_W-1:0] x, input logic [CH_W-1:0] ch);
    int              n;
    bit              last;
    longint          gl, gr, sum_l, sum_r;
    longint unsigned dn;
    pcm_word_t       w;
    n = eff_channels();
    if (int'(ch) >= n) return;
    last = (int'(ch) == n - 1);
    if (!(model_downmix && n > 2)) begin
      w.pcm  = scale_to_pcm(longint'(x), W_ONE);
      w.chan = ch;
      w.last = last;
      pcm_expected.push_back(w);
      return;
    end
    role_gain(model_roles[4*ch +: 4], gl, gr);
    acc_left  = clamp_acc(acc_left + ((longint'(x) * gl) >>> 16));
    acc_right = clamp_acc(acc_right + ((longint'(x) * gr) >>> 16));
    if (!last) return;
    sum_l = 0;
    sum_r = 0;
    for (int c = 0; c < n; c++) begin
      role_gain(model_roles[4*c +: 4], gl, gr);
      sum_l += gl;
      sum_r += gr;
    end
    dn = W_ONE;
    if (sum_l > dn) dn = sum_l;
    if (sum_r > dn) dn = sum_r;
    w.pcm  = scale_to_pcm(acc_left, dn);
    w.chan = 3'd0;
    w.last = 1'b0;
    pcm_expected.push_back(w);
    w.pcm  = scale_to_pcm(acc_right, dn);
    w.chan = 3'd1;
    w.last = 1'b1;
    pcm_expected.push_back(w);
    acc_left  = 0;
    acc_right = 0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      2: v = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      // land exactly on a rounding tie
      3: v = (($urandom_range(0, 32'h0200_0000) - 32'h0100_0000) & 32'hFFFF_FE00) | 32'h100;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic queue_sample(input logic [SAMPLE_W-1:0] v, input int ch);
    sample_word_t s;
    s.value = v;
    s.chan  = ch[CH_W-1:0];
    pending_samples.push_back(s);
    if (ch < eff_channels()) issued++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_DOWNMIX_EN:    model_downmix = val[0];
      CFG_CHANNEL_COUNT: model_count   = val[COUNT_W-1:0];
      CFG_CHANNEL_ROLES: model_roles   = val;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every word is sent and every PCM word is back, then let the divider drain;
  // sample between edges so the driver's updates have settled
  task automatic wait_for_quiet();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_if.valid || pcm_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i) begin : sample_driver
    sample_word_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      gap_left    <= 0;
      burst_left  <= 0;
    end else begin
      if (in_if.valid && in_if.ready) fold_sample(in_if.sample_value, in_if.channel_index);
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left    <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          nxt = pending_samples.pop_front();
          in_if.valid         <= 1'b1;
          in_if.sample_value  <= nxt.value;
          in_if.channel_index <= nxt.chan;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : long_hold
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_request && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: switch between stall patterns at random intervals
  always @(posedge clk_i) begin : pcm_sink
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_mode    <= SINK_OPEN;
      mode_left    <= 0;
      sink_tick    <= 2'd0;
    end else begin
      sink_tick <= sink_tick + 2'd1;
      if (mode_left == 0) begin
        sink_mode <= sink_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(30, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_OPEN:   out_if.ready <= 1'b1;
          SINK_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          SINK_EVERY4: out_if.ready <= (sink_tick == 2'd0);
          default:     out_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : pcm_monitor
    pcm_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pcm_expected.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected PCM word: pcm %0d ch %0d last %0b",
                   out_if.pcm_value, out_if.out_channel, out_if.frame_last);
        mismatch_count++;
      end else begin
        want = pcm_expected.pop_front();
        if (out_if.pcm_value !== want.pcm || out_if.out_channel !== want.chan ||
            out_if.frame_last !== want.last) begin
          if (mismatch_count < MAX_REPORTS)
            $display("PCM mismatch: expected pcm %0d ch %0d last %0b, got pcm %0d ch %0d last %0b",
                     want.pcm, want.chan, want.last,
                     out_if.pcm_value, out_if.out_channel, out_if.frame_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int                 cnt;
    int                 n;
    int                 phase_end;
    int                 pick;
    int                 span;
    logic [ROLES_W-1:0] roles;
    role_e              heavy_roles[4];
    heavy_roles = '{ROLE_LEFT, ROLE_RIGHT, ROLE_CENTER, ROLE_BACK_C};

    rst_ni              = 1'b0;
    cycle_count         = 0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_DOWNMIX_EN;
    cfg_if.data         = '0;
    in_if.valid         = 1'b0;
    in_if.sample_value  = '0;
    in_if.channel_index = '0;
    out_if.ready        = 1'b0;
    hold_request        = 1'b0;
    model_downmix       = 1'b0;
    model_count         = 4'd2;
    model_roles         = '0;
    acc_left            = 0;
    acc_right           = 0;
    issued              = 0;
    mismatch_count      = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Pass-through with reset settings: extremes, rounding ties, clipping, index past count
    queue_sample(32'h7FFF_FFFF, 0);
    queue_sample(32'h8000_0000, 1);
    queue_sample(32'h0000_0100, 0);
    queue_sample(-32'sh100, 1);
    queue_sample(32'h0000_00FF, 0);
    queue_sample(32'h00FF_FF00, 1);
    queue_sample(-32'sh0100_0100, 0);
    queue_sample(32'h1234_5678, 7);
    wait_for_quiet();

    // 5.1 fold-down, LFE weighs nothing
    write_reg(CFG_DOWNMIX_EN, 32'd1);
    write_reg(CFG_CHANNEL_COUNT, 32'd6);
    write_reg(CFG_CHANNEL_ROLES, {8'h00, ROLE_SURR_R, ROLE_SURR_L, ROLE_NONE, ROLE_CENTER,
                                  ROLE_RIGHT, ROLE_LEFT});
    queue_sample(32'h0100_0000, 0);
    queue_sample(-32'sh0100_0000, 1);
    queue_sample(32'h0080_0000, 2);
    queue_sample(32'h7FFF_FFFF, 3);
    queue_sample(32'h8000_0000, 4);
    queue_sample(32'h7FFF_FFFF, 5);
    wait_for_quiet();

    // Every role once, with an inner channel repeated
    write_reg(CFG_CHANNEL_COUNT, 32'd8);
    write_reg(CFG_CHANNEL_ROLES, {ROLE_UNNAMED, ROLE_BACK_C, ROLE_SURR_R, ROLE_SURR_L,
                                  ROLE_CENTER, ROLE_RIGHT, ROLE_LEFT, ROLE_NONE});
    for (int c = 0; c < 8; c++) begin
      queue_sample(rand_sample(), c);
      if (c == 1) queue_sample(rand_sample(), c);
    end
    wait_for_quiet();

    // Zero channels acts as one
    write_reg(CFG_CHANNEL_COUNT, 32'd0);
    write_reg(CFG_CHANNEL_ROLES, 32'd0);
    queue_sample(32'h00C0_0000, 0);
    queue_sample(32'h00C0_0000, 1);
    wait_for_quiet();

    // Oversized count saturates to the channel limit
    write_reg(CFG_DOWNMIX_EN, 32'd0);
    write_reg(CFG_CHANNEL_COUNT, 32'd15);
    write_reg(CFG_CHANNEL_ROLES, 32'hFFFF_FFFF);
    queue_sample(-32'sh0040_0000, 7);
    queue_sample(32'h0040_0000, 6);
    wait_for_quiet();

    // Drive both accumulators into their limits, then pull them back into range
    write_reg(CFG_DOWNMIX_EN, 32'd1);
    write_reg(CFG_CHANNEL_COUNT, 32'd3);
    write_reg(CFG_CHANNEL_ROLES, {20'h0, ROLE_NONE, ROLE_RIGHT, ROLE_LEFT});
    for (int k = 0; k < 260; k++) begin
      queue_sample(32'h7FFF_FFFF, 0);
      queue_sample(32'h8000_0000, 1);
    end
    for (int k = 0; k < 256; k++) begin
      queue_sample(32'h8000_0000, 0);
      queue_sample(32'h7FFF_FFFF, 1);
    end
    queue_sample(32'd0, 2);
    wait_for_quiet();

    // Hold the output off while words keep coming so the input backs up
    write_reg(CFG_DOWNMIX_EN, 32'd0);
    write_reg(CFG_CHANNEL_COUNT, 32'd8);
    @(posedge clk_i);
    hold_request <= 1'b1;
    for (int k = 0; k < 150; k++) queue_sample(rand_sample(), $urandom_range(0, 7));
    wait_for_quiet();

    while (issued < ITEM_TARGET) begin
      write_reg(CFG_DOWNMIX_EN, ($urandom_range(0, 4) != 0) ? 32'd1 : 32'd0);
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 8);
      write_reg(CFG_CHANNEL_COUNT, cnt);
      case ($urandom_range(0, 3))
        0: roles = $urandom();
        1: for (int k = 0; k < 8; k++) roles[4*k +: 4] = heavy_roles[$urandom_range(0, 3)];
        default: for (int k = 0; k < 8; k++) roles[4*k +: 4] = ROLE_W'($urandom_range(0, 7));
      endcase
      write_reg(CFG_CHANNEL_ROLES, roles);
      n = eff_channels();
      phase_end = issued + $urandom_range(60, 140);
      while (issued < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          for (int c = 0; c < n; c++) queue_sample(rand_sample(), c);
        end else if (pick < 16) begin
          // inner channels sometimes arrive twice
          for (int c = 0; c < n; c++) begin
            queue_sample(rand_sample(), c);
            if (c < n - 1 && $urandom_range(0, 2) == 0) queue_sample(rand_sample(), c);
          end
        end else if (pick < 18) begin
          span = $urandom_range(1, 6);
          for (int k = 0; k < span; k++) queue_sample(rand_sample(), $urandom_range(0, 7));
        end else begin
          // broken frame: stop before the last channel
          span = $urandom_range(0, n - 1);
          for (int c = 0; c < span; c++) queue_sample(rand_sample(), c);
        end
      end
      wait_for_quiet();
    end

    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
